// File: rtl/core/gate_netlist_settle_simulator_macros.svh
// ----------------------------------------------------------------------------
// gate netlist settle simulator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GATE_NETLIST_SETTLE_SIMULATOR_MACROS_SVH
`define GATE_NETLIST_SETTLE_SIMULATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define GNSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define GNSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gnss_pkg.sv
// ----------------------------------------------------------------------------
// gnss_pkg
// Types, codes and sizes shared by the gate netlist settle simulator.
// ----------------------------------------------------------------------------
package gnss_pkg;

    // sizes
    localparam int MAX_GATES  = 256;
    localparam int WIRE_COUNT = 512;
    localparam int WIRE_FW    = 9;
    localparam int WIRE_CW    = WIRE_FW + 1;
    localparam int WIRE_AW    = $clog2(WIRE_COUNT);
    localparam int GATE_AW    = $clog2(MAX_GATES);
    localparam int GATE_CW    = GATE_AW + 1;
    localparam int PASS_W     = 8;

    localparam logic [PASS_W-1:0] PASS_LIMIT_RST = 8'd255;

    typedef logic [WIRE_FW-1:0] wire_id_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SET    = 2'd1,
        OP_READ   = 2'd2,
        OP_SETTLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_BUF  = 3'd0,
        K_NOT  = 3'd1,
        K_AND  = 3'd2,
        K_OR   = 3'd3,
        K_NAND = 3'd4,
        K_NOR  = 3'd5,
        K_XOR  = 3'd6,
        K_FADD = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOSETTLE = 2'd2
    } stat_t;

    // input beat
    typedef struct packed {
        op_t      opcode;
        kind_t    gate_kind;
        wire_id_t wire_a;
        wire_id_t wire_b;
        wire_id_t wire_c;
        wire_id_t wire_d;
        wire_id_t wire_e;
        logic     set_value;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic              read_value;
        logic [PASS_W-1:0] pass_count;
        stat_t             status;
    } res_item_t;

    // stored gate record
    typedef struct packed {
        kind_t    kind;
        wire_id_t wire_a;
        wire_id_t wire_b;
        wire_id_t wire_c;
        wire_id_t wire_d;
        wire_id_t wire_e;
    } rec_t;

    // which wire of the current record addresses the wire store
    typedef enum logic [2:0] {
        WS_A   = 3'd0,
        WS_B   = 3'd1,
        WS_C   = 3'd2,
        WS_D   = 3'd3,
        WS_E   = 3'd4,
        WS_OUT = 3'd5
    } wsel_t;

    // where the level just read is captured
    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_A    = 3'd1,
        CAP_B    = 3'd2,
        CAP_C    = 3'd3,
        CAP_RES  = 3'd4
    } cap_t;

    // level written by a put
    typedef enum logic [1:0] {
        VAL_SET   = 2'd0,
        VAL_OUT   = 2'd1,
        VAL_CARRY = 2'd2
    } val_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_SET,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_PASS,
        S_G_FETCH,
        S_G_LOAD,
        S_G_RDA,
        S_G_RDB,
        S_G_RDC,
        S_G_RDO,
        S_G_PUTO,
        S_G_RDE,
        S_G_PUTE,
        S_PASS_END,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic  load_item;
        logic  clr_wr;
        logic  gate_wr;
        logic  rec_load;
        wsel_t rd_sel;
        cap_t  cap;
        logic  put;
        wsel_t put_sel;
        val_t  put_val;
        logic  pass_start;
        logic  idx_inc;
        logic  res_full;
        logic  res_settle;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic full;
        logic empty;
        logic idx_last;
        logic fadd;
        logic chg;
        logic limit_hit;
    } dp_stat_t;

endpackage

// File: rtl/core/gnss_ram.sv
// ----------------------------------------------------------------------------
// gnss_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gnss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/gnss_ctrl.sv
// ----------------------------------------------------------------------------
// gnss_ctrl
// Sequencer for the settle simulator: wire store clearing, item dispatch,
// gate-by-gate evaluation and pass control.
// ----------------------------------------------------------------------------
module gnss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  gnss_pkg::dp_stat_t   stat,
    output gnss_pkg::ctrl_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    gnss_pkg::state_t state_reg;
    gnss_pkg::state_t state_next;

    // state register, clearing pass first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gnss_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = gnss_pkg::WS_A;
        cmd.put_sel = gnss_pkg::WS_A;
        cmd.put_val = gnss_pkg::VAL_SET;
        cmd.cap    = gnss_pkg::CAP_NONE;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (state_reg)
            gnss_pkg::S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = gnss_pkg::S_IDLE;
                end
            end

            gnss_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = gnss_pkg::S_DISPATCH;
                end
            end

            gnss_pkg::S_DISPATCH:
            begin
                unique case (stat.op)
                    gnss_pkg::OP_ADD:    state_next = gnss_pkg::S_ADD;
                    gnss_pkg::OP_SET:    state_next = gnss_pkg::S_SET;
                    gnss_pkg::OP_READ:   state_next = gnss_pkg::S_RD_ISSUE;
                    gnss_pkg::OP_SETTLE: state_next = gnss_pkg::S_PASS;
                    default:             state_next = gnss_pkg::S_DONE;
                endcase
            end

            // append a record unless the store is full
            gnss_pkg::S_ADD:
            begin
                if (stat.full)
                begin
                    cmd.res_full = 1'b1;
                end
                else
                begin
                    cmd.gate_wr = 1'b1;
                end
                state_next = gnss_pkg::S_DONE;
            end

            gnss_pkg::S_SET:
            begin
                cmd.put     = 1'b1;
                cmd.put_sel = gnss_pkg::WS_A;
                cmd.put_val = gnss_pkg::VAL_SET;
                state_next  = gnss_pkg::S_DONE;
            end

            gnss_pkg::S_RD_ISSUE:
            begin
                cmd.rd_sel = gnss_pkg::WS_A;
                state_next = gnss_pkg::S_RD_TAKE;
            end

            gnss_pkg::S_RD_TAKE:
            begin
                cmd.cap    = gnss_pkg::CAP_RES;
                state_next = gnss_pkg::S_DONE;
            end

            // open a pass over the gate store
            gnss_pkg::S_PASS:
            begin
                cmd.pass_start = 1'b1;
                if (stat.empty)
                begin
                    state_next = gnss_pkg::S_PASS_END;
                end
                else
                begin
                    state_next = gnss_pkg::S_G_FETCH;
                end
            end

            gnss_pkg::S_G_FETCH:
            begin
                state_next = gnss_pkg::S_G_LOAD;
            end

            gnss_pkg::S_G_LOAD:
            begin
                cmd.rec_load = 1'b1;
                state_next   = gnss_pkg::S_G_RDA;
            end

            // operand reads, each captured in the next cycle
            gnss_pkg::S_G_RDA:
            begin
                cmd.rd_sel = gnss_pkg::WS_A;
                state_next = gnss_pkg::S_G_RDB;
            end

            gnss_pkg::S_G_RDB:
            begin
                cmd.cap    = gnss_pkg::CAP_A;
                cmd.rd_sel = gnss_pkg::WS_B;
                state_next = gnss_pkg::S_G_RDC;
            end

            gnss_pkg::S_G_RDC:
            begin
                cmd.cap    = gnss_pkg::CAP_B;
                cmd.rd_sel = gnss_pkg::WS_C;
                state_next = gnss_pkg::S_G_RDO;
            end

            gnss_pkg::S_G_RDO:
            begin
                cmd.cap    = gnss_pkg::CAP_C;
                cmd.rd_sel = gnss_pkg::WS_OUT;
                state_next = gnss_pkg::S_G_PUTO;
            end

            // write the main output, then the carry for an adder
            gnss_pkg::S_G_PUTO:
            begin
                cmd.put     = 1'b1;
                cmd.put_sel = gnss_pkg::WS_OUT;
                cmd.put_val = gnss_pkg::VAL_OUT;
                if (stat.fadd)
                begin
                    state_next = gnss_pkg::S_G_RDE;
                end
                else if (stat.idx_last)
                begin
                    state_next = gnss_pkg::S_PASS_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = gnss_pkg::S_G_FETCH;
                end
            end

            gnss_pkg::S_G_RDE:
            begin
                cmd.rd_sel = gnss_pkg::WS_E;
                state_next = gnss_pkg::S_G_PUTE;
            end

            gnss_pkg::S_G_PUTE:
            begin
                cmd.put     = 1'b1;
                cmd.put_sel = gnss_pkg::WS_E;
                cmd.put_val = gnss_pkg::VAL_CARRY;
                if (stat.idx_last)
                begin
                    state_next = gnss_pkg::S_PASS_END;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = gnss_pkg::S_G_FETCH;
                end
            end

            // another pass while wires still move and the limit allows
            gnss_pkg::S_PASS_END:
            begin
                if (stat.chg && !stat.limit_hit)
                begin
                    state_next = gnss_pkg::S_PASS;
                end
                else
                begin
                    cmd.res_settle = 1'b1;
                    state_next     = gnss_pkg::S_DONE;
                end
            end

            gnss_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = gnss_pkg::S_IDLE;
            end

            default:
            begin
                state_next = gnss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/gnss_dp.sv
// ----------------------------------------------------------------------------
// gnss_dp
// Datapath: gate store, wire store, gate evaluation, pass counting and the
// result registers.
// ----------------------------------------------------------------------------
module gnss_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gnss_pkg::in_item_t              item,
    input  logic                            cfg_we,
    input  logic [gnss_pkg::PASS_W-1:0]     cfg_wdata,
    input  gnss_pkg::ctrl_cmd_t             cmd,
    output gnss_pkg::dp_stat_t              stat,
    output gnss_pkg::res_item_t             result
);

    localparam int REC_W = $bits(gnss_pkg::rec_t);

    // control state
    logic [gnss_pkg::GATE_CW-1:0] total_reg;
    logic [gnss_pkg::GATE_AW-1:0] idx_reg;
    logic [gnss_pkg::WIRE_AW-1:0] clr_reg;
    logic [gnss_pkg::PASS_W-1:0]  limit_reg;
    logic [gnss_pkg::PASS_W-1:0]  pass_reg;
    logic                         chg_reg;
    logic                         rd_ok_reg;
    logic                         rdv_reg;
    gnss_pkg::stat_t              stat_reg;
    gnss_pkg::op_t                op_reg;

    // payload
    gnss_pkg::rec_t               rec_reg;
    logic                         setv_reg;
    logic                         a_reg;
    logic                         b_reg;
    logic                         c_reg;

    logic [REC_W-1:0]             gram_q;
    logic                         wram_q;
    logic                         wram_we;
    logic [gnss_pkg::WIRE_AW-1:0] wram_waddr;
    logic                         wram_wdata;

    gnss_pkg::wire_id_t           rd_wire;
    gnss_pkg::wire_id_t           pt_wire;
    logic                         rd_in;
    logic                         pt_in;
    logic                         lvl;
    logic                         out1;
    logic                         carry;
    logic                         put_v;
    logic [gnss_pkg::PASS_W-1:0]  eff_limit;

    // pick one wire of a record
    function automatic gnss_pkg::wire_id_t sel_wire(input gnss_pkg::rec_t r,
                                                    input gnss_pkg::wsel_t s);
        gnss_pkg::wire_id_t w;
        case (s)
            gnss_pkg::WS_A: w = r.wire_a;
            gnss_pkg::WS_B: w = r.wire_b;
            gnss_pkg::WS_C: w = r.wire_c;
            gnss_pkg::WS_D: w = r.wire_d;
            gnss_pkg::WS_E: w = r.wire_e;
            gnss_pkg::WS_OUT:
            begin
                case (r.kind) inside
                    gnss_pkg::K_BUF, gnss_pkg::K_NOT: w = r.wire_b;
                    gnss_pkg::K_FADD:                 w = r.wire_d;
                    default:                          w = r.wire_c;
                endcase
            end
            default: w = r.wire_a;
        endcase
        return w;
    endfunction

    // wire addressing and range checks
    always_comb
    begin
        rd_wire = sel_wire(rec_reg, cmd.rd_sel);
        pt_wire = sel_wire(rec_reg, cmd.put_sel);
        rd_in   = {1'b0, rd_wire} < gnss_pkg::WIRE_CW'(gnss_pkg::WIRE_COUNT);
        pt_in   = {1'b0, pt_wire} < gnss_pkg::WIRE_CW'(gnss_pkg::WIRE_COUNT);
        lvl     = rd_ok_reg & wram_q;
    end

    // gate function on the captured operands
    always_comb
    begin
        case (rec_reg.kind)
            gnss_pkg::K_BUF:  out1 = a_reg;
            gnss_pkg::K_NOT:  out1 = ~a_reg;
            gnss_pkg::K_AND:  out1 = a_reg & b_reg;
            gnss_pkg::K_OR:   out1 = a_reg | b_reg;
            gnss_pkg::K_NAND: out1 = ~(a_reg & b_reg);
            gnss_pkg::K_NOR:  out1 = ~(a_reg | b_reg);
            gnss_pkg::K_XOR:  out1 = a_reg ^ b_reg;
            default:          out1 = a_reg ^ b_reg ^ c_reg;
        endcase
        carry = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
        case (cmd.put_val)
            gnss_pkg::VAL_SET:   put_v = setv_reg;
            gnss_pkg::VAL_OUT:   put_v = out1;
            gnss_pkg::VAL_CARRY: put_v = carry;
            default:             put_v = 1'b0;
        endcase
    end

    // wire store write port, shared by clearing and puts
    always_comb
    begin
        if (cmd.clr_wr)
        begin
            wram_we    = 1'b1;
            wram_waddr = clr_reg;
            wram_wdata = 1'b0;
        end
        else
        begin
            wram_we    = cmd.put & pt_in;
            wram_waddr = pt_wire[gnss_pkg::WIRE_AW-1:0];
            wram_wdata = put_v;
        end
    end

    gnss_ram #(
        .WIDTH (1),
        .DEPTH (gnss_pkg::WIRE_COUNT)
    ) u_wire_ram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .raddr (rd_wire[gnss_pkg::WIRE_AW-1:0]),
        .rdata (wram_q)
    );

    gnss_ram #(
        .WIDTH (REC_W),
        .DEPTH (gnss_pkg::MAX_GATES)
    ) u_gate_ram (
        .clk   (clk),
        .we    (cmd.gate_wr),
        .waddr (total_reg[gnss_pkg::GATE_AW-1:0]),
        .wdata (rec_reg),
        .raddr (idx_reg),
        .rdata (gram_q)
    );

    // counters, flags and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            idx_reg   <= '0;
            clr_reg   <= '0;
            limit_reg <= gnss_pkg::PASS_LIMIT_RST;
            pass_reg  <= '0;
            chg_reg   <= 1'b0;
            rd_ok_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            stat_reg  <= gnss_pkg::ST_OK;
            op_reg    <= gnss_pkg::OP_ADD;
        end
        else
        begin
            rd_ok_reg <= rd_in;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.load_item)
            begin
                op_reg   <= item.opcode;
                pass_reg <= '0;
                rdv_reg  <= 1'b0;
                stat_reg <= gnss_pkg::ST_OK;
            end
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.gate_wr)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.pass_start)
            begin
                pass_reg <= pass_reg + 1'b1;
                chg_reg  <= 1'b0;
                idx_reg  <= '0;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.put)
            begin
                chg_reg <= chg_reg | (pt_in & (lvl != put_v));
            end
            if (cmd.cap == gnss_pkg::CAP_RES)
            begin
                rdv_reg <= lvl;
            end
            if (cmd.res_full)
            begin
                stat_reg <= gnss_pkg::ST_FULL;
            end
            if (cmd.res_settle)
            begin
                stat_reg <= chg_reg ? gnss_pkg::ST_NOSETTLE : gnss_pkg::ST_OK;
            end
        end
    end

    // record and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rec_reg.kind   <= item.gate_kind;
            rec_reg.wire_a <= item.wire_a;
            rec_reg.wire_b <= item.wire_b;
            rec_reg.wire_c <= item.wire_c;
            rec_reg.wire_d <= item.wire_d;
            rec_reg.wire_e <= item.wire_e;
            setv_reg       <= item.set_value;
        end
        else if (cmd.rec_load)
        begin
            rec_reg <= gnss_pkg::rec_t'(gram_q);
        end
        case (cmd.cap)
            gnss_pkg::CAP_A: a_reg <= lvl;
            gnss_pkg::CAP_B: b_reg <= lvl;
            gnss_pkg::CAP_C: c_reg <= lvl;
            default:         ;
        endcase
    end

    // status towards the controller
    always_comb
    begin
        eff_limit      = (limit_reg == '0) ? gnss_pkg::PASS_W'(1) : limit_reg;
        stat.op        = op_reg;
        stat.clr_last  = clr_reg == gnss_pkg::WIRE_AW'(gnss_pkg::WIRE_COUNT - 1);
        stat.full      = total_reg == gnss_pkg::GATE_CW'(gnss_pkg::MAX_GATES);
        stat.empty     = total_reg == '0;
        stat.idx_last  = ({1'b0, idx_reg} + gnss_pkg::GATE_CW'(1)) == total_reg;
        stat.fadd      = rec_reg.kind == gnss_pkg::K_FADD;
        stat.chg       = chg_reg;
        stat.limit_hit = pass_reg >= eff_limit;
    end

    assign result.read_value = rdv_reg;
    assign result.pass_count = pass_reg;
    assign result.status     = stat_reg;

endmodule

// File: rtl/core/gate_netlist_settle_simulator.sv
// ----------------------------------------------------------------------------
// gate_netlist_settle_simulator
// Gate-level netlist simulator with iterative settling over a stored netlist.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low; every item gives one
// result beat on result, flagged by done for a single cycle, and the receiver
// cannot hold it off, so it must take it in that cycle. After reset the block
// sweeps the 512-entry wire store to zero, one wire a cycle, and stays busy
// while it does so. A settle item runs passes over the stored gates: each
// gate is one record fetch from the gate store followed by one wire-store
// access a cycle for its operand reads and output writes. pass_limit may be
// written at any time the block is idle; zero acts as one.
`include "gate_netlist_settle_simulator_macros.svh"

module gate_netlist_settle_simulator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  gnss_pkg::in_item_t           item,
    output logic                         busy,
    output logic                         done,
    output gnss_pkg::res_item_t          result,
    input  logic                         cfg_we,
    input  logic [gnss_pkg::PASS_W-1:0]  cfg_wdata
);

    gnss_pkg::ctrl_cmd_t cmd;
    gnss_pkg::dp_stat_t  stat;

    // sequencer
    gnss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // stores and evaluation
    gnss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    // checks
    `GNSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `GNSS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for more than one cycle")
    `GNSS_ASSERT_NOW(a_done_busy, done, busy, "result strobe while idle")
    `GNSS_ASSERT_NOW(a_settle_fields, done && (result.pass_count != '0), (result.read_value == 1'b0) && (result.status != gnss_pkg::ST_FULL), "settle result mixes fields of other items")

endmodule

// File: dv/tb_gate_netlist_settle_simulator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gate_netlist_settle_simulator
// Self-checking bench for the gate netlist settle simulator. A directed table
// builds a small netlist covering every gate kind, a gated ring oscillator
// and the empty-store settle, then random phases under several pass limits
// mix gate loads, wire writes, wire reads and settles. The bench finishes by
// filling the gate store past its end, then settles and reads. Every result beat
// is checked field by field against the directed table or an in-bench netlist evaluator.
// ----------------------------------------------------------------------------
module tb_gate_netlist_settle_simulator;
    import gnss_pkg::*;

    localparam int DIR_ROWS = 25;
    localparam int N_PHASES = 7;

    typedef struct packed {
        in_item_t  beat;
        logic      typed;
        res_item_t want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    in_item_t            item;
    logic                busy;
    logic                done;
    res_item_t           result;
    logic                cfg_we;
    logic [PASS_W-1:0]   cfg_wdata;

    // evaluator copy of the netlist, wire levels and pass limit
    rec_t                gate_store [MAX_GATES];
    logic                wire_lvl [WIRE_COUNT];
    int unsigned         gate_cnt;
    int unsigned         fadd_cnt;
    logic [PASS_W-1:0]   pass_lim;

    res_item_t           awaited_results [$];
    res_item_t           want_beat;
    dir_row_t            dir_tab [DIR_ROWS];

    longint unsigned     cyc_cnt = 0;
    longint unsigned     cycle_budget = 0;
    int unsigned         err_cnt = 0;
    int unsigned         checked_cnt = 0;
    int unsigned         beat_cnt = 0;
    int unsigned         settle_cnt = 0;
    int unsigned         limit_hit_cnt = 0;
    int unsigned         full_cnt = 0;

    gate_netlist_settle_simulator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // wire store access
    function automatic logic lvl_read(wire_id_t w);
        if (w >= WIRE_COUNT)
        begin
            return 1'b0;
        end
        return wire_lvl[w];
    endfunction

    // returns one when the level actually changes
    function automatic logic lvl_write(wire_id_t w, logic v);
        if (w >= WIRE_COUNT || wire_lvl[w] == v)
        begin
            return 1'b0;
        end
        wire_lvl[w] = v;
        return 1'b1;
    endfunction

    // one gate evaluation, outputs written straight away
    function automatic logic gate_eval(rec_t g);
        logic       a;
        logic       b;
        logic       x;
        logic       ch;
        logic [1:0] s;
        a = lvl_read(g.wire_a);
        b = lvl_read(g.wire_b);
        x = 1'b0;
        case (g.kind)
            K_BUF:  return lvl_write(g.wire_b, a);
            K_NOT:  return lvl_write(g.wire_b, !a);
            K_AND:  x = a & b;
            K_OR:   x = a | b;
            K_NAND: x = !(a & b);
            K_NOR:  x = !(a | b);
            K_XOR:  x = a ^ b;
            default:
            begin
                s  = {1'b0, a} + {1'b0, b} + {1'b0, lvl_read(g.wire_c)};
                ch = lvl_write(g.wire_d, s[0]);
                ch = lvl_write(g.wire_e, s[1]) | ch;
                return ch;
            end
        endcase
        return lvl_write(g.wire_c, x);
    endfunction

    // applies one beat to the netlist copy and gives the result it should produce
    function automatic res_item_t simulate_item(in_item_t it);
        res_item_t   r;
        rec_t        g;
        int unsigned lim;
        int unsigned passes;
        logic        changed;
        r = '0;
        r.status = ST_OK;
        cycle_budget += 8;
        case (it.opcode)
            OP_ADD:
            begin
                if (gate_cnt >= MAX_GATES)
                begin
                    r.status = ST_FULL;
                    full_cnt++;
                end
                else
                begin
                    g.kind   = it.gate_kind;
                    g.wire_a = it.wire_a;
                    g.wire_b = it.wire_b;
                    g.wire_c = it.wire_c;
                    g.wire_d = it.wire_d;
                    g.wire_e = it.wire_e;
                    gate_store[gate_cnt] = g;
                    if (it.gate_kind == K_FADD)
                    begin
                        fadd_cnt++;
                    end
                    gate_cnt++;
                end
            end
            OP_SET:
            begin
                void'(lvl_write(it.wire_a, it.set_value));
            end
            OP_READ:
            begin
                r.read_value = lvl_read(it.wire_a);
            end
            default:
            begin
                lim     = (pass_lim == '0) ? 1 : pass_lim;
                passes  = 0;
                changed = 1'b1;
                while (changed && passes < lim)
                begin
                    changed = 1'b0;
                    passes++;
                    for (int i = 0; i < gate_cnt; i++)
                    begin
                        if (gate_eval(gate_store[i]))
                        begin
                            changed = 1'b1;
                        end
                    end
                end
                r.pass_count = passes[PASS_W-1:0];
                if (changed)
                begin
                    r.status = ST_NOSETTLE;
                    limit_hit_cnt++;
                end
                settle_cnt++;
                cycle_budget += passes * (2 + 7 * gate_cnt + 2 * fadd_cnt);
            end
        endcase
        return r;
    endfunction

    // directed table row
    function automatic dir_row_t row(op_t op, kind_t k, int a, int b, int c, int d, int e,
                                     logic v, logic typed, logic rd, int pc, stat_t st);
        dir_row_t t;
        t.beat.opcode     = op;
        t.beat.gate_kind  = k;
        t.beat.wire_a     = wire_id_t'(a);
        t.beat.wire_b     = wire_id_t'(b);
        t.beat.wire_c     = wire_id_t'(c);
        t.beat.wire_d     = wire_id_t'(d);
        t.beat.wire_e     = wire_id_t'(e);
        t.beat.set_value  = v;
        t.typed           = typed;
        t.want.read_value = rd;
        t.want.pass_count = PASS_W'(pc);
        t.want.status     = st;
        return t;
    endfunction

    // mostly a small pool so gates interact, sometimes the full range
    function automatic wire_id_t pick_wire();
        if ($urandom_range(0, 3) == 0)
        begin
            return wire_id_t'($urandom_range(0, WIRE_COUNT - 1));
        end
        return wire_id_t'($urandom_range(0, 15));
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned r;
        r = $urandom_range(0, 99);
        it.opcode    = (r < 20) ? OP_ADD : (r < 55) ? OP_SET : (r < 85) ? OP_READ : OP_SETTLE;
        it.gate_kind = kind_t'(3'($urandom_range(0, 7)));
        it.wire_a    = pick_wire();
        it.wire_b    = pick_wire();
        it.wire_c    = pick_wire();
        it.wire_d    = pick_wire();
        it.wire_e    = pick_wire();
        it.set_value = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // mostly back to back or short, now and then a long pause
    function automatic int pick_gap(logic quiet);
        int unsigned r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR cycle %0d: %s", cyc_cnt, msg);
        err_cnt++;
    endtask

    // hands one beat over and records what it should produce
    task automatic send_beat(in_item_t beat, int gap, logic typed, res_item_t want);
        res_item_t got;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= beat;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        got = simulate_item(beat);
        awaited_results.push_back(typed ? want : got);
        cycle_budget += gap;
        beat_cnt++;
    endtask

    // register write once the block has drained
    task automatic write_pass_limit(logic [PASS_W-1:0] v);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pass_lim = v;
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                report_mismatch("result beat with nothing awaited");
            end
            else
            begin
                want_beat = awaited_results.pop_front();
                if (result.read_value !== want_beat.read_value)
                begin
                    report_mismatch($sformatf("beat %0d read_value %b, want %b", checked_cnt,
                                              result.read_value, want_beat.read_value));
                end
                if (result.pass_count !== want_beat.pass_count)
                begin
                    report_mismatch($sformatf("beat %0d pass_count %0d, want %0d", checked_cnt,
                                              result.pass_count, want_beat.pass_count));
                end
                if (result.status !== want_beat.status)
                begin
                    report_mismatch($sformatf("beat %0d status %0d, want %0d", checked_cnt,
                                              result.status, want_beat.status));
                end
            end
            checked_cnt++;
        end
    end

    // watchdog scaled on the work handed over so far
    always @(posedge clk)
    begin
        cyc_cnt = cyc_cnt + 1;
        if (cyc_cnt > 4 * cycle_budget + 30000)
        begin
            $display("Timeout after %0d cycles, %0d beats still awaited", cyc_cnt,
                     awaited_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        in_item_t          beat;
        logic              quiet;
        logic [PASS_W-1:0] lim;
        int                n;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        foreach (wire_lvl[i])
        begin
            wire_lvl[i] = 1'b0;
        end
        gate_cnt = 0;
        fadd_cnt = 0;
        pass_lim = PASS_LIMIT_RST;

        // directed netlist: op, kind, a, b, c, d, e, level, typed, read, passes, status
        dir_tab[0]  = row(OP_READ,   K_BUF,  0,   0,   0,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[1]  = row(OP_READ,   K_FADD, 511, 511, 511, 511, 511, 1, 1, 0, 0,   ST_OK);
        dir_tab[2]  = row(OP_SETTLE, K_BUF,  0,   0,   0,   0,   0,   0, 1, 0, 1,   ST_OK);
        dir_tab[3]  = row(OP_SET,    K_BUF,  511, 0,   0,   0,   0,   1, 1, 0, 0,   ST_OK);
        dir_tab[4]  = row(OP_READ,   K_BUF,  511, 0,   0,   0,   0,   0, 1, 1, 0,   ST_OK);
        dir_tab[5]  = row(OP_SET,    K_BUF,  0,   0,   0,   0,   0,   1, 1, 0, 0,   ST_OK);
        dir_tab[6]  = row(OP_SET,    K_BUF,  1,   0,   0,   0,   0,   1, 1, 0, 0,   ST_OK);
        dir_tab[7]  = row(OP_ADD,    K_BUF,  0,   2,   511, 511, 511, 1, 1, 0, 0,   ST_OK);
        dir_tab[8]  = row(OP_ADD,    K_NOT,  0,   3,   0,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[9]  = row(OP_ADD,    K_AND,  0,   1,   4,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[10] = row(OP_ADD,    K_OR,   3,   1,   5,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[11] = row(OP_ADD,    K_NAND, 0,   1,   6,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[12] = row(OP_ADD,    K_NOR,  3,   4,   7,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[13] = row(OP_ADD,    K_XOR,  0,   3,   8,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[14] = row(OP_ADD,    K_FADD, 0,   1,   2,   9,   10,  0, 1, 0, 0,   ST_OK);
        // ring oscillator on wire 20, enabled by wire 21
        dir_tab[15] = row(OP_ADD,    K_NAND, 21,  20,  20,  0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[16] = row(OP_SETTLE, K_BUF,  0,   0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);
        dir_tab[17] = row(OP_READ,   K_BUF,  9,   0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);
        dir_tab[18] = row(OP_READ,   K_BUF,  10,  0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);
        dir_tab[19] = row(OP_SET,    K_BUF,  21,  0,   0,   0,   0,   1, 1, 0, 0,   ST_OK);
        dir_tab[20] = row(OP_SETTLE, K_BUF,  0,   0,   0,   0,   0,   0, 1, 0, 255,
                          ST_NOSETTLE);
        dir_tab[21] = row(OP_SET,    K_BUF,  21,  0,   0,   0,   0,   0, 1, 0, 0,   ST_OK);
        dir_tab[22] = row(OP_SETTLE, K_BUF,  0,   0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);
        dir_tab[23] = row(OP_READ,   K_BUF,  20,  0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);
        dir_tab[24] = row(OP_READ,   K_BUF,  7,   0,   0,   0,   0,   0, 0, 0, 0,   ST_OK);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset pass limit
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_beat(dir_tab[i].beat, pick_gap(1'b0), dir_tab[i].typed, dir_tab[i].want);
        end

        // random phases, each under its own pass limit
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:       begin lim = 8'd255; n = 30; end
                1:       begin lim = 8'd0;   n = 60; end
                2:       begin lim = 8'd1;   n = 60; end
                default: begin lim = PASS_W'($urandom_range(2, 9)); n = 35; end
            endcase
            write_pass_limit(lim);
            quiet = (p % 3 == 1);
            repeat (n)
            begin
                send_beat(random_item(), pick_gap(quiet), 1'b0, '0);
            end
        end

        // fill the gate store and push past its end
        write_pass_limit(8'd3);
        while (full_cnt < 2)
        begin
            beat = random_item();
            beat.opcode = OP_ADD;
            send_beat(beat, pick_gap(1'b0), 1'b0, '0);
        end
        beat = random_item();
        beat.opcode = OP_SETTLE;
        send_beat(beat, pick_gap(1'b0), 1'b0, '0);
        repeat (6)
        begin
            beat = random_item();
            beat.opcode = OP_READ;
            send_beat(beat, pick_gap(1'b0), 1'b0, '0);
        end
        beat.opcode = OP_SETTLE;
        send_beat(beat, pick_gap(1'b0), 1'b0, '0);
        start <= 1'b0;

        // drain, then watch for stray beats
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        $display("Covered %0d beats: %0d settles (%0d stopped by the pass limit), %0d adds %s",
                 beat_cnt, settle_cnt, limit_hit_cnt, full_cnt, "refused on a full store");
        $display("%0d gates stored, %0d result beats checked, %0d mismatches",
                 gate_cnt, checked_cnt, err_cnt);
        if (err_cnt == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/gnss_pkg.sv
rtl/core/gnss_ram.sv
rtl/core/gnss_ctrl.sv
rtl/core/gnss_dp.sv
rtl/core/gate_netlist_settle_simulator.sv
dv/tb_gate_netlist_settle_simulator.sv
